// ===== rtl/core/hms_pkg.sv =====
// ----------------------------------------------------------------------------
// hms_pkg: shared definitions for the homogeneous medium sampler
// Widths, pipeline depths, register codes, request types and reciprocal table.
// ----------------------------------------------------------------------------
package hms_pkg;

    localparam int NCH    = 3;
    localparam int CH_W   = 2;
    localparam int SIG_W  = 24;
    localparam int EXT_W  = SIG_W + 1;
    localparam int U_W    = 16;
    localparam int DIST_W = 32;
    localparam int TR_W   = 17;
    localparam int PDF_W  = 25;

    localparam int LOG_STEPS    = 16;
    localparam int DIV_STEPS    = 36;
    localparam int K_STEPS      = 5;
    localparam int TAYLOR_TERMS = 13;
    localparam int EXP_LAT      = 1 + K_STEPS + 1 + 3 * (TAYLOR_TERMS - 1) + 1;

    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);

    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    localparam logic [31:0] LN2_Q32        = 32'd2977044472;
    localparam int          EXP_LIMIT_INT  = 12;
    localparam logic [15:0] ROUND_Q16      = 16'd32768;
    localparam logic [SIG_W-1:0] SCATTER_RESET = 24'd52429;

    localparam logic OP_SAMPLE   = 1'b0;
    localparam logic OP_TRANSMIT = 1'b1;

    localparam logic [CH_W-1:0] CH_RED   = 2'd0;
    localparam logic [CH_W-1:0] CH_GREEN = 2'd1;
    localparam logic [CH_W-1:0] CH_BLUE  = 2'd2;

    localparam logic [2:0] REG_ABSORB_RED    = 3'd0;
    localparam logic [2:0] REG_ABSORB_GREEN  = 3'd1;
    localparam logic [2:0] REG_ABSORB_BLUE   = 3'd2;
    localparam logic [2:0] REG_SCATTER_RED   = 3'd3;
    localparam logic [2:0] REG_SCATTER_GREEN = 3'd4;
    localparam logic [2:0] REG_SCATTER_BLUE  = 3'd5;

    typedef struct packed {
        logic [NCH-1:0][SIG_W-1:0] absorb;
        logic [NCH-1:0][SIG_W-1:0] scatter;
    } t_cfg;

    typedef struct packed {
        logic              op;
        logic [CH_W-1:0]   ch;
        logic [DIST_W-1:0] t;
        logic              scat;
        logic [DIST_W-1:0] exp_len;
    } t_job;

    // floor(2^36 / n) for the small constant divisors of the series.
    function automatic logic [35:0] recip_q36(input logic [3:0] n);
        logic [35:0] m;
        case (n)
            4'd2:    m = 36'd34359738368;
            4'd3:    m = 36'd22906492245;
            4'd4:    m = 36'd17179869184;
            4'd5:    m = 36'd13743895347;
            4'd6:    m = 36'd11453246122;
            4'd7:    m = 36'd9817068105;
            4'd8:    m = 36'd8589934592;
            4'd9:    m = 36'd7635497415;
            4'd10:   m = 36'd6871947673;
            4'd11:   m = 36'd6247225157;
            4'd12:   m = 36'd5726623061;
            4'd13:   m = 36'd5286113595;
            default: m = 36'd0;
        endcase
        return m;
    endfunction

endpackage

// ===== rtl/core/hms_front.sv =====
// ----------------------------------------------------------------------------
// hms_front: channel choice, free-flight log and distance divide
// Picks the channel, forms -ln(1-u) by repeated squaring and divides it by the
// channel extinction in a bit-per-stage restoring divider.
// ----------------------------------------------------------------------------
module hms_front import hms_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_operation,
    input  logic [U_W-1:0]    i_u_channel,
    input  logic [U_W-1:0]    i_u_distance,
    input  logic [DIST_W-1:0] i_max_distance,
    input  logic [DIST_W-1:0] i_query_distance,
    input  t_cfg              i_cfg,
    output logic              o_push,
    output t_job              o_job
);

    localparam int E_W  = 5;
    localparam int LG_W = E_W + LOG_STEPS;
    localparam int NL_W = 20;
    localparam int D_W  = NL_W + 16;

    typedef struct packed {
        logic              op;
        logic [CH_W-1:0]   ch;
        logic [DIST_W-1:0] maxd;
        logic [DIST_W-1:0] qd;
    } t_fmeta;

    // Request decode
    logic [U_W+1:0] ch_prod;
    logic [CH_W-1:0] ch_raw;
    logic [CH_W-1:0] ch_sel;
    logic [U_W:0]   x;
    logic [E_W-1:0] e;
    logic [31:0]    m0;

    assign ch_prod = ({2'b00, i_u_channel} << 1) + {2'b00, i_u_channel};
    assign ch_raw  = ch_prod[U_W+1:U_W];
    assign ch_sel  = (ch_raw > CH_BLUE) ? CH_BLUE : ch_raw;
    assign x       = 17'h10000 - {1'b0, i_u_distance};

    always_comb begin
        e = '0;
        for (int b = 0; b <= U_W; b++) begin
            if (x[b]) begin
                e = E_W'(b);
            end
        end
    end

    assign m0 = {15'b0, x} << (5'd31 - e);

    logic           r_s0_v;
    logic [31:0]    r_s0_m;
    logic [LG_W-1:0] r_s0_lg;
    t_fmeta         r_s0_meta;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v <= 1'b0;
        end else begin
            r_s0_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s0_m    <= m0;
        r_s0_lg   <= {e, {LOG_STEPS{1'b0}}};
        r_s0_meta <= '{op: i_operation, ch: ch_sel, maxd: i_max_distance,
                       qd: i_query_distance};
    end

    // Log2 fraction bits, one squaring per stage
    logic            r_lg_v   [LOG_STEPS];
    logic [31:0]     r_lg_m   [LOG_STEPS];
    logic [LG_W-1:0] r_lg_lg  [LOG_STEPS];
    t_fmeta          r_lg_meta[LOG_STEPS];
    logic            lg_v_in  [LOG_STEPS];
    logic [31:0]     lg_m_in  [LOG_STEPS];
    logic [LG_W-1:0] lg_lg_in [LOG_STEPS];
    t_fmeta          lg_meta_in[LOG_STEPS];

    always_comb begin
        lg_v_in[0]    = r_s0_v;
        lg_m_in[0]    = r_s0_m;
        lg_lg_in[0]   = r_s0_lg;
        lg_meta_in[0] = r_s0_meta;
        for (int i = 1; i < LOG_STEPS; i++) begin
            lg_v_in[i]    = r_lg_v[i-1];
            lg_m_in[i]    = r_lg_m[i-1];
            lg_lg_in[i]   = r_lg_lg[i-1];
            lg_meta_in[i] = r_lg_meta[i-1];
        end
    end

    for (genvar i = 0; i < LOG_STEPS; i++) begin : g_log
        logic [63:0] sq;
        logic [32:0] m2;

        assign sq = {32'b0, lg_m_in[i]} * {32'b0, lg_m_in[i]};
        assign m2 = sq[63:31];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_lg_v[i] <= 1'b0;
            end else begin
                r_lg_v[i] <= lg_v_in[i];
            end
        end

        always_ff @(posedge i_clk) begin
            r_lg_m[i]    <= m2[32] ? m2[32:1] : m2[31:0];
            r_lg_lg[i]   <= lg_lg_in[i] | (m2[32] ? (LG_W'(1) << (LOG_STEPS - 1 - i))
                                                  : LG_W'(0));
            r_lg_meta[i] <= lg_meta_in[i];
        end
    end

    // Scale by ln2 and look up the chosen extinction
    logic [LG_W-1:0] l_val;
    logic [63:0]     nl_prod;
    logic            r_nl_v;
    logic [D_W-1:0]  r_nl_d;
    logic [EXT_W-1:0] r_nl_st;
    t_fmeta          r_nl_meta;

    assign l_val   = (LG_W'(16) << 16) - r_lg_lg[LOG_STEPS-1];
    assign nl_prod = {{(64-LG_W){1'b0}}, l_val} * {32'b0, LN2_Q32} + 64'h8000_0000;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nl_v <= 1'b0;
        end else begin
            r_nl_v <= r_lg_v[LOG_STEPS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_nl_d    <= {nl_prod[NL_W+31:32], 16'b0};
        r_nl_st   <= {1'b0, i_cfg.absorb[r_lg_meta[LOG_STEPS-1].ch]}
                   + {1'b0, i_cfg.scatter[r_lg_meta[LOG_STEPS-1].ch]};
        r_nl_meta <= r_lg_meta[LOG_STEPS-1];
    end

    // Restoring divider, one quotient bit per stage. A zero divisor gives an
    // all-ones quotient, which saturates below.
    logic             r_dv_v   [DIV_STEPS];
    logic [EXT_W-1:0] r_dv_rem [DIV_STEPS];
    logic [D_W-1:0]   r_dv_q   [DIV_STEPS];
    logic [D_W-1:0]   r_dv_d   [DIV_STEPS];
    logic [EXT_W-1:0] r_dv_st  [DIV_STEPS];
    t_fmeta           r_dv_meta[DIV_STEPS];
    logic             dv_v_in  [DIV_STEPS];
    logic [EXT_W-1:0] dv_rem_in[DIV_STEPS];
    logic [D_W-1:0]   dv_q_in  [DIV_STEPS];
    logic [D_W-1:0]   dv_d_in  [DIV_STEPS];
    logic [EXT_W-1:0] dv_st_in [DIV_STEPS];
    t_fmeta           dv_meta_in[DIV_STEPS];

    always_comb begin
        dv_v_in[0]    = r_nl_v;
        dv_rem_in[0]  = '0;
        dv_q_in[0]    = '0;
        dv_d_in[0]    = r_nl_d;
        dv_st_in[0]   = r_nl_st;
        dv_meta_in[0] = r_nl_meta;
        for (int i = 1; i < DIV_STEPS; i++) begin
            dv_v_in[i]    = r_dv_v[i-1];
            dv_rem_in[i]  = r_dv_rem[i-1];
            dv_q_in[i]    = r_dv_q[i-1];
            dv_d_in[i]    = r_dv_d[i-1];
            dv_st_in[i]   = r_dv_st[i-1];
            dv_meta_in[i] = r_dv_meta[i-1];
        end
    end

    for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
        logic [EXT_W:0] rem_sh;
        logic [EXT_W:0] diff;
        logic           ge;

        assign rem_sh = {dv_rem_in[i], dv_d_in[i][DIV_STEPS-1-i]};
        assign ge     = rem_sh >= {1'b0, dv_st_in[i]};
        assign diff   = rem_sh - {1'b0, dv_st_in[i]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[i] <= 1'b0;
            end else begin
                r_dv_v[i] <= dv_v_in[i];
            end
        end

        always_ff @(posedge i_clk) begin
            r_dv_rem[i]  <= ge ? diff[EXT_W-1:0] : rem_sh[EXT_W-1:0];
            r_dv_q[i]    <= {dv_q_in[i][D_W-2:0], ge};
            r_dv_d[i]    <= dv_d_in[i];
            r_dv_st[i]   <= dv_st_in[i];
            r_dv_meta[i] <= dv_meta_in[i];
        end
    end

    // Saturate, classify and pick the exposure distance
    logic [D_W-1:0]    q_fin;
    t_fmeta            m_fin;
    logic [DIST_W-1:0] t_fin;
    logic              scat_fin;

    assign q_fin    = r_dv_q[DIV_STEPS-1];
    assign m_fin    = r_dv_meta[DIV_STEPS-1];
    assign t_fin    = ((r_dv_st[DIV_STEPS-1] == '0) || (q_fin[D_W-1:DIST_W] != '0))
                    ? '1 : q_fin[DIST_W-1:0];
    assign scat_fin = (m_fin.op == OP_SAMPLE) && (t_fin < m_fin.maxd);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_push <= 1'b0;
        end else begin
            o_push <= r_dv_v[DIV_STEPS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        o_job <= '{op: m_fin.op, ch: m_fin.ch, t: t_fin, scat: scat_fin,
                   exp_len: (m_fin.op == OP_TRANSMIT) ? m_fin.qd : t_fin};
    end

endmodule

// ===== rtl/core/hms_fifo.sv =====
// ----------------------------------------------------------------------------
// hms_fifo: request queue between the front and back pipelines
// A small register queue; the head entry is presented directly.
// ----------------------------------------------------------------------------
module hms_fifo import hms_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_job,
    output logic o_full
);

    t_job             r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_head;
    logic [PTR_W-1:0] r_tail;
    logic [PTR_W:0]   r_count;
    logic [PTR_W:0]   n_count;

    assign o_valid = r_count != '0;
    assign o_full  = r_count == (PTR_W+1)'(FIFO_DEPTH);
    assign o_job   = r_mem[r_head];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_tail <= r_tail + 1'b1;
            end
            if (i_pop) begin
                r_head <= r_head + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_tail] <= i_job;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && o_full) |-> i_pop)
        else $error("request queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("request queue underflow");

endmodule

// ===== rtl/core/hms_exp.sv =====
// ----------------------------------------------------------------------------
// hms_exp: pipelined transmittance lane, exp(-sigma_t * d) in Q1.16
// Range reduction by ln2 over five stages, then a truncated alternating
// series with one multiply, reciprocal and correction stage per term.
// ----------------------------------------------------------------------------
module hms_exp import hms_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [EXT_W-1:0]  i_ext,
    input  logic [DIST_W-1:0] i_dist,
    output logic              o_valid,
    output logic [TR_W-1:0]   o_tr
);

    localparam int X_W = EXT_W + DIST_W;
    localparam int R_W = 36;
    localparam int KW  = K_STEPS;
    localparam int NT  = TAYLOR_TERMS - 1;
    localparam int S_W = 33;

    typedef struct packed {
        logic [31:0]    term;
        logic [31:0]    r;
        logic [S_W-1:0] sum;
        logic [KW-1:0]  k;
        logic           big;
    } t_tay;

    // Exponent product
    logic           r_p_v;
    logic [X_W-1:0] r_p_x;
    logic           p_big;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_v <= 1'b0;
        end else begin
            r_p_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p_x <= X_W'(i_ext) * X_W'(i_dist);
    end

    assign p_big = r_p_x[X_W-1:32] >= (X_W-32)'(EXP_LIMIT_INT);

    // k = floor(x / ln2), one bit per stage
    logic          r_k_v  [KW];
    logic [R_W-1:0] r_k_rem[KW];
    logic [KW-1:0] r_k_k  [KW];
    logic          r_k_big[KW];
    logic          k_v_in  [KW];
    logic [R_W-1:0] k_rem_in[KW];
    logic [KW-1:0] k_k_in  [KW];
    logic          k_big_in[KW];

    always_comb begin
        k_v_in[0]   = r_p_v;
        k_rem_in[0] = r_p_x[R_W-1:0];
        k_k_in[0]   = '0;
        k_big_in[0] = p_big;
        for (int j = 1; j < KW; j++) begin
            k_v_in[j]   = r_k_v[j-1];
            k_rem_in[j] = r_k_rem[j-1];
            k_k_in[j]   = r_k_k[j-1];
            k_big_in[j] = r_k_big[j-1];
        end
    end

    for (genvar j = 0; j < KW; j++) begin : g_kdiv
        logic [R_W-1:0] dv;
        logic           ge;

        assign dv = R_W'(LN2_Q32) << (KW - 1 - j);
        assign ge = k_rem_in[j] >= dv;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_k_v[j] <= 1'b0;
            end else begin
                r_k_v[j] <= k_v_in[j];
            end
        end

        always_ff @(posedge i_clk) begin
            r_k_rem[j] <= ge ? (k_rem_in[j] - dv) : k_rem_in[j];
            r_k_k[j]   <= k_k_in[j] | (ge ? (KW'(1) << (KW - 1 - j)) : KW'(0));
            r_k_big[j] <= k_big_in[j];
        end
    end

    // First term of the series is r itself.
    logic r_i_v;
    t_tay r_i_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i_v <= 1'b0;
        end else begin
            r_i_v <= r_k_v[KW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_i_s <= '{term: r_k_rem[KW-1][31:0], r: r_k_rem[KW-1][31:0],
                   sum: 33'h1_0000_0000 - {1'b0, r_k_rem[KW-1][31:0]},
                   k: r_k_k[KW-1], big: r_k_big[KW-1]};
    end

    // Remaining terms, three stages each
    logic        r_ta_v[NT];
    logic        r_tb_v[NT];
    logic        r_tc_v[NT];
    t_tay        r_ta_s[NT];
    t_tay        r_tb_s[NT];
    t_tay        r_tc_s[NT];
    logic [31:0] r_ta_p[NT];
    logic [31:0] r_tb_p[NT];
    logic [31:0] r_tb_q[NT];
    logic        tay_v_in[NT];
    t_tay        tay_s_in[NT];

    always_comb begin
        tay_v_in[0] = r_i_v;
        tay_s_in[0] = r_i_s;
        for (int i = 1; i < NT; i++) begin
            tay_v_in[i] = r_tc_v[i-1];
            tay_s_in[i] = r_tc_s[i-1];
        end
    end

    for (genvar i = 0; i < NT; i++) begin : g_term
        localparam int N = i + 2;
        logic [63:0] pa;
        logic [67:0] pb;
        logic [35:0] qn;
        logic [35:0] rem;
        logic [31:0] q;
        t_tay        s_out;

        assign pa  = {32'b0, tay_s_in[i].term} * {32'b0, tay_s_in[i].r};
        assign pb  = 68'(r_ta_p[i]) * 68'(recip_q36(4'(N)));
        assign qn  = 36'(r_tb_q[i]) * 36'(N);
        assign rem = 36'(r_tb_p[i]) - qn;
        assign q   = r_tb_q[i] + 32'(rem >= 36'(N));

        always_comb begin
            s_out      = r_tb_s[i];
            s_out.term = q;
            if ((N % 2) == 1) begin
                s_out.sum = r_tb_s[i].sum - {1'b0, q};
            end else begin
                s_out.sum = r_tb_s[i].sum + {1'b0, q};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ta_v[i] <= 1'b0;
                r_tb_v[i] <= 1'b0;
                r_tc_v[i] <= 1'b0;
            end else begin
                r_ta_v[i] <= tay_v_in[i];
                r_tb_v[i] <= r_ta_v[i];
                r_tc_v[i] <= r_tb_v[i];
            end
        end

        always_ff @(posedge i_clk) begin
            r_ta_s[i] <= tay_s_in[i];
            r_ta_p[i] <= pa[63:32];
            r_tb_s[i] <= r_ta_s[i];
            r_tb_p[i] <= r_ta_p[i];
            r_tb_q[i] <= pb[67:36];
            r_tc_s[i] <= s_out;
        end
    end

    // Scale by 2^-(k+16) with rounding
    t_tay        s_fin;
    logic [5:0]  k6;
    logic [33:0] rnd;
    logic [33:0] shr;

    assign s_fin = r_tc_s[NT-1];
    assign k6    = {1'b0, s_fin.k};
    assign rnd   = {1'b0, s_fin.sum} + (34'd1 << (6'd15 + k6));
    assign shr   = rnd >> (6'd16 + k6);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_tc_v[NT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        o_tr <= s_fin.big ? '0 : shr[TR_W-1:0];
    end

endmodule

// ===== rtl/core/hms_back.sv =====
// ----------------------------------------------------------------------------
// hms_back: transmittance lanes, weights and channel-mean density
// Takes one queued request per cycle and never stalls.
// ----------------------------------------------------------------------------
module hms_back import hms_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  t_job              i_job,
    input  t_cfg              i_cfg,
    output logic              o_pop,
    output logic              o_valid,
    output logic [SIG_W-1:0]  o_weight_red,
    output logic [SIG_W-1:0]  o_weight_green,
    output logic [SIG_W-1:0]  o_weight_blue,
    output logic [PDF_W-1:0]  o_sample_pdf,
    output logic [DIST_W-1:0] o_sampled_distance,
    output logic              o_scattered,
    output logic [CH_W-1:0]   o_chosen_channel
);

    localparam int WP_W = TR_W + SIG_W;
    localparam int DP_W = TR_W + EXT_W;
    localparam int PS_W = PDF_W + 2;
    localparam int PM_W = PS_W + 36;
    localparam int PC_W = PS_W + 2;

    typedef struct packed {
        logic              op;
        logic [CH_W-1:0]   ch;
        logic [DIST_W-1:0] t;
        logic              scat;
    } t_bmeta;

    assign o_pop = i_valid;

    logic [NCH-1:0][EXT_W-1:0] ext;
    logic [NCH-1:0]            lane_v;
    logic [NCH-1:0][TR_W-1:0]  lane_tr;

    for (genvar c = 0; c < NCH; c++) begin : g_lane
        assign ext[c] = {1'b0, i_cfg.absorb[c]} + {1'b0, i_cfg.scatter[c]};

        hms_exp u_exp (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (i_valid),
            .i_ext   (ext[c]),
            .i_dist  (i_job.exp_len),
            .o_valid (lane_v[c]),
            .o_tr    (lane_tr[c])
        );
    end

    // Side information travels beside the lanes.
    logic   r_mv[EXP_LAT];
    t_bmeta r_m [EXP_LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < EXP_LAT; i++) begin
                r_mv[i] <= 1'b0;
            end
        end else begin
            r_mv[0] <= i_valid;
            for (int i = 1; i < EXP_LAT; i++) begin
                r_mv[i] <= r_mv[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_m[0] <= '{op: i_job.op, ch: i_job.ch, t: i_job.t, scat: i_job.scat};
        for (int i = 1; i < EXP_LAT; i++) begin
            r_m[i] <= r_m[i-1];
        end
    end

    t_bmeta m_lane;
    assign m_lane = r_m[EXP_LAT-1];

    // Weights and densities
    logic                      r_w1_v;
    t_bmeta                    r_w1_m;
    logic [NCH-1:0][SIG_W-1:0] r_w1_w;
    logic [NCH-1:0][EXT_W-1:0] r_w1_d;

    for (genvar c = 0; c < NCH; c++) begin : g_weight
        logic [WP_W-1:0] wp;
        logic [DP_W-1:0] dp;

        assign wp = WP_W'(lane_tr[c]) * WP_W'(i_cfg.scatter[c]) + WP_W'(ROUND_Q16);
        assign dp = DP_W'(ext[c]) * DP_W'(lane_tr[c]) + DP_W'(ROUND_Q16);

        always_ff @(posedge i_clk) begin
            r_w1_w[c] <= m_lane.scat ? wp[SIG_W+15:16] : SIG_W'(lane_tr[c]);
            r_w1_d[c] <= m_lane.scat ? dp[EXT_W+15:16] : EXT_W'(lane_tr[c]);
        end
    end

    // Mean over channels: rounded division by three via reciprocal.
    logic                      r_w2_v;
    t_bmeta                    r_w2_m;
    logic [NCH-1:0][SIG_W-1:0] r_w2_w;
    logic [PS_W-1:0]           r_w2_sum;
    logic                      r_w3_v;
    t_bmeta                    r_w3_m;
    logic [NCH-1:0][SIG_W-1:0] r_w3_w;
    logic [PS_W-1:0]           r_w3_sum;
    logic [PS_W-1:0]           r_w3_q;
    logic [PM_W-1:0]           pm;
    logic [PC_W-1:0]           pc_rem;
    logic [PS_W-1:0]           pdf_q;

    assign pm     = PM_W'(r_w2_sum) * PM_W'(recip_q36(4'd3));
    assign pc_rem = PC_W'(r_w3_sum) - PC_W'(r_w3_q) * PC_W'(3);
    assign pdf_q  = r_w3_q + PS_W'(pc_rem >= PC_W'(3));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w1_v  <= 1'b0;
            r_w2_v  <= 1'b0;
            r_w3_v  <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_w1_v  <= r_mv[EXP_LAT-1];
            r_w2_v  <= r_w1_v;
            r_w3_v  <= r_w2_v;
            o_valid <= r_w3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_w1_m   <= m_lane;
        r_w2_m   <= r_w1_m;
        r_w2_w   <= r_w1_w;
        r_w2_sum <= PS_W'(r_w1_d[0]) + PS_W'(r_w1_d[1]) + PS_W'(r_w1_d[2]) + PS_W'(1);
        r_w3_m   <= r_w2_m;
        r_w3_w   <= r_w2_w;
        r_w3_sum <= r_w2_sum;
        r_w3_q   <= pm[PM_W-1:36];

        o_weight_red   <= r_w3_w[CH_RED];
        o_weight_green <= r_w3_w[CH_GREEN];
        o_weight_blue  <= r_w3_w[CH_BLUE];
        if (r_w3_m.op == OP_TRANSMIT) begin
            o_sample_pdf       <= '0;
            o_sampled_distance <= '0;
            o_scattered        <= 1'b0;
            o_chosen_channel   <= CH_RED;
        end else begin
            o_sample_pdf       <= pdf_q[PDF_W-1:0];
            o_sampled_distance <= r_w3_m.t;
            o_scattered        <= r_w3_m.scat;
            o_chosen_channel   <= r_w3_m.ch;
        end
    end

    a_lane_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        lane_v == {NCH{r_mv[EXP_LAT-1]}})
        else $error("transmittance lanes out of step with side information");

    a_lane_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        lane_v[0] |-> ##4 o_valid)
        else $error("lane output did not reach the result strobe");

endmodule

// ===== rtl/core/homogeneous_medium_sampler_top.sv =====
// ----------------------------------------------------------------------------
// homogeneous_medium_sampler_top: fixed-point homogeneous medium sampler
// Fully pipelined; accepts one request per clock while busy is low and returns one
// result per request after the log and divide stages of the front pipeline,
// the request queue, the transmittance lanes and the weight and channel-mean
// stages. The result strobe o_valid lasts one cycle and results cannot be held
// off, so capture them when they appear. busy only rises if the request queue
// fills, which does not happen in normal operation. Write the coefficient
// registers only while no request is in flight.
// ----------------------------------------------------------------------------
module homogeneous_medium_sampler_top import hms_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_operation,
    input  logic [U_W-1:0]     i_u_channel,
    input  logic [U_W-1:0]     i_u_distance,
    input  logic [DIST_W-1:0]  i_max_distance,
    input  logic [DIST_W-1:0]  i_query_distance,
    output logic               o_valid,
    output logic [SIG_W-1:0]   o_weight_red,
    output logic [SIG_W-1:0]   o_weight_green,
    output logic [SIG_W-1:0]   o_weight_blue,
    output logic [PDF_W-1:0]   o_sample_pdf,
    output logic [DIST_W-1:0]  o_sampled_distance,
    output logic               o_scattered,
    output logic [CH_W-1:0]    o_chosen_channel,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    // Coefficient registers
    t_cfg       r_cfg;
    logic       cfg_we;
    logic [2:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite;
    assign cfg_idx = paddr[PADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.absorb  <= '0;
            r_cfg.scatter <= {NCH{SCATTER_RESET}};
        end else if (cfg_we) begin
            unique case (cfg_idx)
                REG_ABSORB_RED:    r_cfg.absorb[CH_RED]    <= pwdata[SIG_W-1:0];
                REG_ABSORB_GREEN:  r_cfg.absorb[CH_GREEN]  <= pwdata[SIG_W-1:0];
                REG_ABSORB_BLUE:   r_cfg.absorb[CH_BLUE]   <= pwdata[SIG_W-1:0];
                REG_SCATTER_RED:   r_cfg.scatter[CH_RED]   <= pwdata[SIG_W-1:0];
                REG_SCATTER_GREEN: r_cfg.scatter[CH_GREEN] <= pwdata[SIG_W-1:0];
                REG_SCATTER_BLUE:  r_cfg.scatter[CH_BLUE]  <= pwdata[SIG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_ABSORB_RED:    prdata = PDATA_W'(r_cfg.absorb[CH_RED]);
            REG_ABSORB_GREEN:  prdata = PDATA_W'(r_cfg.absorb[CH_GREEN]);
            REG_ABSORB_BLUE:   prdata = PDATA_W'(r_cfg.absorb[CH_BLUE]);
            REG_SCATTER_RED:   prdata = PDATA_W'(r_cfg.scatter[CH_RED]);
            REG_SCATTER_GREEN: prdata = PDATA_W'(r_cfg.scatter[CH_GREEN]);
            REG_SCATTER_BLUE:  prdata = PDATA_W'(r_cfg.scatter[CH_BLUE]);
            default:           prdata = '0;
        endcase
    end

    // Datapath
    logic accept;
    logic front_push;
    t_job front_job;
    logic q_valid;
    t_job q_job;
    logic q_full;
    logic back_pop;

    assign busy   = q_full;
    assign accept = start && !busy;

    hms_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (accept),
        .i_operation      (i_operation),
        .i_u_channel      (i_u_channel),
        .i_u_distance     (i_u_distance),
        .i_max_distance   (i_max_distance),
        .i_query_distance (i_query_distance),
        .i_cfg            (r_cfg),
        .o_push           (front_push),
        .o_job            (front_job)
    );

    hms_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_job   (front_job),
        .i_pop   (back_pop),
        .o_valid (q_valid),
        .o_job   (q_job),
        .o_full  (q_full)
    );

    hms_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (q_valid),
        .i_job              (q_job),
        .i_cfg              (r_cfg),
        .o_pop              (back_pop),
        .o_valid            (o_valid),
        .o_weight_red       (o_weight_red),
        .o_weight_green     (o_weight_green),
        .o_weight_blue      (o_weight_blue),
        .o_sample_pdf       (o_sample_pdf),
        .o_sampled_distance (o_sampled_distance),
        .o_scattered        (o_scattered),
        .o_chosen_channel   (o_chosen_channel)
    );

endmodule
